/* hdl/axlu_pkg.sv */
// ----------------------------------------------------------------------------
// axlu_pkg
// Shared constants, register codes and controller/datapath interface types
// for the linear interpolation upsampler.
// ----------------------------------------------------------------------------
package axlu_pkg;

	localparam int MAX_INPUT_COUNT  = 4096;
	localparam int MAX_FILL_PER_GAP = 62;

	localparam int SAMPLE_W  = 32;
	localparam int CNT_W     = 13;
	localparam int IDX_W     = $clog2(MAX_INPUT_COUNT);
	localparam int FILL_W    = 6;
	localparam int DIFF_W    = SAMPLE_W + 1;
	localparam int DIVR_W    = 13;
	localparam int DIV_STEPS = DIFF_W;
	localparam int DIV_CNT_W = $clog2(DIV_STEPS);

	localparam logic [CNT_W-1:0] TARGET_RESET = CNT_W'(2);
	localparam logic [CNT_W-1:0] COUNT_RESET  = CNT_W'(2);

	// configuration register indexes
	localparam logic REG_TARGET_POINTS = 1'b0;
	localparam logic REG_INPUT_COUNT   = 1'b1;

	typedef struct packed {
		logic accept;
		logic emit_prev;
		logic emit_fill;
		logic emit_last;
		logic mode_load;
		logic step_load;
		logic finish;
	} axlu_cmd_t;

	typedef struct packed {
		logic idx_zero;
		logic need_div;
		logic n_one;
		logic is_last;
		logic f_zero;
		logic fill_last;
		logic div_busy;
		logic out_free;
	} axlu_sts_t;

endpackage

/* hdl/axlu_div.sv */
// ----------------------------------------------------------------------------
// axlu_div
// Restoring serial divider, one quotient bit per cycle, unsigned operands.
// ----------------------------------------------------------------------------
module axlu_div (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             start,
	input  logic [axlu_pkg::DIFF_W-1:0]      dividend,
	input  logic [axlu_pkg::DIVR_W-1:0]      divisor,
	output logic                             busy,
	output logic [axlu_pkg::DIFF_W-1:0]      quotient,
	output logic [axlu_pkg::DIVR_W-1:0]      remainder
);

	logic                              busy_q;
	logic [axlu_pkg::DIV_CNT_W-1:0]    cnt_q;
	logic [axlu_pkg::DIVR_W-1:0]       rem_q;
	logic [axlu_pkg::DIFF_W-1:0]       quo_q;
	logic [axlu_pkg::DIVR_W-1:0]       dvs_q;
	logic [axlu_pkg::DIVR_W:0]         trial;
	logic [axlu_pkg::DIVR_W:0]         trial_sub;
	logic                              fits;

	always_comb begin
		trial     = {rem_q, quo_q[axlu_pkg::DIFF_W-1]};
		fits      = trial >= {1'b0, dvs_q};
		trial_sub = trial - {1'b0, dvs_q};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= '0;
		end else if (busy_q) begin
			if (cnt_q == axlu_pkg::DIV_CNT_W'(axlu_pkg::DIV_STEPS - 1)) begin
				busy_q <= 1'b0;
			end
			cnt_q <= cnt_q + axlu_pkg::DIV_CNT_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= dividend;
			dvs_q <= divisor;
		end else if (busy_q) begin
			rem_q <= fits ? trial_sub[axlu_pkg::DIVR_W-1:0] : trial[axlu_pkg::DIVR_W-1:0];
			quo_q <= {quo_q[axlu_pkg::DIFF_W-2:0], fits};
		end
	end

	assign busy      = busy_q;
	assign quotient  = quo_q;
	assign remainder = rem_q;

endmodule

/* hdl/axlu_dp.sv */
// ----------------------------------------------------------------------------
// axlu_dp
// Datapath: config registers, sequence state, gap setup, fill accumulator,
// shared serial divider and output register.
// ----------------------------------------------------------------------------
module axlu_dp (
	input  logic                                clk,
	input  logic                                arst_n,
	input  axlu_pkg::axlu_cmd_t                 cmd,
	output axlu_pkg::axlu_sts_t                 sts,
	input  logic signed [axlu_pkg::SAMPLE_W-1:0] sample,
	input  logic                                cfg_valid,
	input  logic                                cfg_index,
	input  logic [axlu_pkg::CNT_W-1:0]          cfg_data,
	input  logic                                out_stall,
	output logic                                out_valid,
	output logic signed [axlu_pkg::SAMPLE_W-1:0] value,
	output logic                                is_original,
	output logic                                last,
	output logic                                config_error
);

	localparam int SW = axlu_pkg::SAMPLE_W;
	localparam int DW = axlu_pkg::DIFF_W;
	localparam int CW = axlu_pkg::CNT_W;
	localparam int IW = axlu_pkg::IDX_W;
	localparam int FW = axlu_pkg::FILL_W;
	localparam int RW = axlu_pkg::DIVR_W;

	// control state
	logic [CW-1:0]  tgt_q;
	logic [CW-1:0]  count_q;
	logic [IW-1:0]  idx_q;
	logic [FW-1:0]  base_q;
	logic [IW-1:0]  extra_q;
	logic           err_q;
	logic [SW-1:0]  prev_q;
	logic           out_valid_q;
	logic [FW-1:0]  k_q;

	// per-item payload
	logic [SW-1:0]  x_q;
	logic           is_last_q;
	logic [FW-1:0]  f_q;
	logic           neg_q;
	logic [DW-1:0]  step_q;
	logic [DW-1:0]  acc_q;
	logic [SW-1:0]  value_q;
	logic           orig_q;
	logic           last_q;
	logic           err_out_q;

	logic [CW-1:0]  n_eff;
	logic           n_one;
	logic           n_ge_tgt;
	logic [IW-1:0]  gaps;
	logic [CW-1:0]  extra_pts;
	logic           idx_zero;
	logic           need_div;
	logic [IW-1:0]  gap;
	logic [FW:0]    f_wide;
	logic [FW-1:0]  f_now;
	logic           last_now;
	logic [DW-1:0]  diff;
	logic [DW-1:0]  mag;
	logic           div_start;
	logic [DW-1:0]  div_dividend;
	logic [RW-1:0]  div_divisor;
	logic           div_busy;
	logic [DW-1:0]  div_q;
	logic [RW-1:0]  div_r;
	logic [CW:0]    most;
	logic           mode_err;
	logic [DW-1:0]  fill_sum;
	logic [DW-1:0]  step_val;
	logic           out_free;

	always_comb begin
		if (count_q == '0) begin
			n_eff = CW'(1);
		end else if (count_q > CW'(axlu_pkg::MAX_INPUT_COUNT)) begin
			n_eff = CW'(axlu_pkg::MAX_INPUT_COUNT);
		end else begin
			n_eff = count_q;
		end
		n_one     = n_eff == CW'(1);
		n_ge_tgt  = n_eff >= tgt_q;
		gaps      = IW'(n_eff - CW'(1));
		extra_pts = tgt_q - n_eff;
		idx_zero  = idx_q == '0;
		need_div  = idx_zero && !n_ge_tgt && !n_one;

		// fills for the gap that ends at the incoming sample
		gap    = idx_q - IW'(1);
		f_wide = {1'b0, base_q} + {{FW{1'b0}}, (gap < extra_q)};
		if (err_q) begin
			f_now = '0;
		end else if (f_wide > (FW+1)'(axlu_pkg::MAX_FILL_PER_GAP)) begin
			f_now = FW'(axlu_pkg::MAX_FILL_PER_GAP);
		end else begin
			f_now = f_wide[FW-1:0];
		end
		last_now = ({1'b0, idx_q} + CW'(1)) >= n_eff;

		diff = {sample[SW-1], sample} - {prev_q[SW-1], prev_q};
		mag  = diff[DW-1] ? (DW'(0) - diff) : diff;

		div_start = cmd.accept && (need_div || (!idx_zero && (f_now != '0)));
		if (idx_zero) begin
			div_dividend = DW'(extra_pts);
			div_divisor  = RW'(gaps);
		end else begin
			div_dividend = mag;
			div_divisor  = RW'(f_now) + RW'(1);
		end

		most     = {1'b0, div_q[CW-1:0]} + {{CW{1'b0}}, (div_r != '0)};
		mode_err = (div_q[DW-1:CW] != '0)
			|| (most > (CW+1)'(axlu_pkg::MAX_FILL_PER_GAP));

		step_val = neg_q ? (DW'(0) - div_q) : div_q;
		fill_sum = acc_q + step_q;
		out_free = !out_valid_q || !out_stall;
	end

	axlu_div u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (div_start),
		.dividend  (div_dividend),
		.divisor   (div_divisor),
		.busy      (div_busy),
		.quotient  (div_q),
		.remainder (div_r)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tgt_q       <= axlu_pkg::TARGET_RESET;
			count_q     <= axlu_pkg::COUNT_RESET;
			idx_q       <= '0;
			base_q      <= '0;
			extra_q     <= '0;
			err_q       <= 1'b0;
			prev_q      <= '0;
			out_valid_q <= 1'b0;
			k_q         <= '0;
		end else begin
			if (cfg_valid) begin
				case (cfg_index)
					axlu_pkg::REG_TARGET_POINTS: tgt_q   <= cfg_data;
					axlu_pkg::REG_INPUT_COUNT:   count_q <= cfg_data;
					default: ;
				endcase
			end

			// mode choice at sequence start when no division is needed
			if (cmd.accept && idx_zero && !need_div) begin
				base_q  <= '0;
				extra_q <= '0;
				err_q   <= n_one && !n_ge_tgt;
			end

			if (cmd.mode_load) begin
				if (mode_err) begin
					base_q  <= '0;
					extra_q <= '0;
					err_q   <= 1'b1;
				end else begin
					base_q  <= div_q[FW-1:0];
					extra_q <= div_r[IW-1:0];
					err_q   <= 1'b0;
				end
			end

			if (cmd.step_load) begin
				k_q <= '0;
			end else if (cmd.emit_fill) begin
				k_q <= k_q + FW'(1);
			end

			if (cmd.finish) begin
				idx_q  <= is_last_q ? '0 : idx_q + IW'(1);
				prev_q <= x_q;
			end

			if (cmd.emit_prev || cmd.emit_fill || cmd.emit_last) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			x_q       <= sample;
			is_last_q <= last_now;
			f_q       <= idx_zero ? '0 : f_now;
			neg_q     <= diff[DW-1];
		end

		if (cmd.step_load) begin
			step_q <= step_val;
			acc_q  <= {prev_q[SW-1], prev_q};
		end else if (cmd.emit_fill) begin
			acc_q <= fill_sum;
		end

		if (cmd.emit_prev) begin
			value_q   <= prev_q;
			orig_q    <= 1'b1;
			last_q    <= 1'b0;
			err_out_q <= err_q;
		end else if (cmd.emit_fill) begin
			value_q   <= fill_sum[SW-1:0];
			orig_q    <= 1'b0;
			last_q    <= 1'b0;
			err_out_q <= err_q;
		end else if (cmd.emit_last) begin
			value_q   <= x_q;
			orig_q    <= 1'b1;
			last_q    <= 1'b1;
			err_out_q <= err_q;
		end
	end

	always_comb begin
		sts.idx_zero  = idx_zero;
		sts.need_div  = need_div;
		sts.n_one     = n_one;
		sts.is_last   = is_last_q;
		sts.f_zero    = f_q == '0;
		sts.fill_last = k_q == (f_q - FW'(1));
		sts.div_busy  = div_busy;
		sts.out_free  = out_free;
	end

	assign out_valid    = out_valid_q;
	assign value        = value_q;
	assign is_original  = orig_q;
	assign last         = last_q;
	assign config_error = err_out_q;

endmodule

/* hdl/axlu_ctrl.sv */
// ----------------------------------------------------------------------------
// axlu_ctrl
// Sequencer: takes one sample at a time, waits on the divider and steps the
// datapath through the previous sample, the fills and the closing sample.
// ----------------------------------------------------------------------------
module axlu_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_stall,
	input  axlu_pkg::axlu_sts_t sts,
	output axlu_pkg::axlu_cmd_t cmd
);

	typedef enum logic [2:0] {
		S_IDLE,
		S_MODE_WAIT,
		S_PREV,
		S_STEP_WAIT,
		S_FILL,
		S_LAST,
		S_FIN
	} state_t;

	state_t state_q;

	always_comb begin
		cmd           = '0;
		cmd.accept    = (state_q == S_IDLE) && in_valid;
		cmd.mode_load = (state_q == S_MODE_WAIT) && !sts.div_busy;
		cmd.emit_prev = (state_q == S_PREV) && sts.out_free;
		cmd.step_load = (state_q == S_STEP_WAIT) && !sts.div_busy;
		cmd.emit_fill = (state_q == S_FILL) && sts.out_free;
		cmd.emit_last = (state_q == S_LAST) && sts.out_free;
		cmd.finish    = state_q == S_FIN;
		in_stall      = state_q != S_IDLE;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						if (!sts.idx_zero) begin
							state_q <= S_PREV;
						end else if (sts.need_div) begin
							state_q <= S_MODE_WAIT;
						end else if (sts.n_one) begin
							state_q <= S_LAST;
						end else begin
							state_q <= S_FIN;
						end
					end
				end
				S_MODE_WAIT: begin
					if (!sts.div_busy) begin
						state_q <= S_FIN;
					end
				end
				S_PREV: begin
					if (sts.out_free) begin
						if (!sts.f_zero) begin
							state_q <= S_STEP_WAIT;
						end else if (sts.is_last) begin
							state_q <= S_LAST;
						end else begin
							state_q <= S_FIN;
						end
					end
				end
				S_STEP_WAIT: begin
					if (!sts.div_busy) begin
						state_q <= S_FILL;
					end
				end
				S_FILL: begin
					// last fill of the gap goes out this cycle
					if (sts.out_free && sts.fill_last) begin
						state_q <= sts.is_last ? S_LAST : S_FIN;
					end
				end
				S_LAST: begin
					if (sts.out_free) begin
						state_q <= S_FIN;
					end
				end
				S_FIN: begin
					state_q <= S_IDLE;
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

endmodule

/* hdl/axis_linear_upsampler_core.sv */
// ----------------------------------------------------------------------------
// axis_linear_upsampler_core
// Pads a sequence of Q16.16 samples up to a target point count by linear
// interpolation; later samples emit the previous one and the gap's fills.
// ----------------------------------------------------------------------------
//   channel | handshake              | payload
//   --------+------------------------+-----------------------------------------
//   in      | in_valid / in_stall    | sample
//   out     | out_valid / out_stall  | value, is_original, last, config_error
//   cfg     | cfg_valid / cfg_ready  | cfg_index, cfg_data
//
// One sample at a time. A sample whose gap has fills waits on the 33-step
// serial divider that forms the step before its fills go out; the first sample
// of a sequence that needs fills waits on it for the fills-per-gap division.
// Reset is asynchronous and leaves target_points = 2, input_count = 2.
// A single output register lets the next sample in while the last beat waits.
// ----------------------------------------------------------------------------
module axis_linear_upsampler_core (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	output logic                                in_stall,
	input  logic signed [axlu_pkg::SAMPLE_W-1:0] sample,
	output logic                                out_valid,
	input  logic                                out_stall,
	output logic signed [axlu_pkg::SAMPLE_W-1:0] value,
	output logic                                is_original,
	output logic                                last,
	output logic                                config_error,
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic                                cfg_index,
	input  logic [axlu_pkg::CNT_W-1:0]          cfg_data
);

	axlu_pkg::axlu_cmd_t cmd;
	axlu_pkg::axlu_sts_t sts;

	assign cfg_ready = 1'b1;

	axlu_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.sts      (sts),
		.cmd      (cmd)
	);

	axlu_dp u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.sts          (sts),
		.sample       (sample),
		.cfg_valid    (cfg_valid),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.out_stall    (out_stall),
		.out_valid    (out_valid),
		.value        (value),
		.is_original  (is_original),
		.last         (last),
		.config_error (config_error)
	);

	// a fill is never the closing beat and never carries the error flag
	a_fill_not_last: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !is_original) |-> (!last && !config_error))
		else $error("fill beat marked last or flagged");

	// every accepted sample keeps the sequencer busy in the next cycle
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall) |=> in_stall)
		else $error("sequencer idle right after accept");

	// the divider has finished whenever the sequencer is ready for a sample
	a_div_idle: assert property (@(posedge clk) disable iff (!arst_n)
		!in_stall |-> !sts.div_busy)
		else $error("divider busy while accepting samples");

endmodule
